// ----- rtl/core/firsat_pkg.sv -----
// ----------------------------------------------------------------------------
// firsat_pkg
// Shared types and constants of the saturating int16 FIR filter.
// ----------------------------------------------------------------------------
package firsat_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int PROD_W         = 32;
	localparam int COEF_FRAC_BITS = 15;
	localparam int TAPS_W         = 6;
	localparam int CIDX_W         = 5;

	localparam logic [TAPS_W-1:0] TAP_COUNT_RESET = 6'd21;

	// Operation codes of an input transaction
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// Register word index on the configuration port
	localparam logic REG_TAP_COUNT = 1'b0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAT_MAX = 16'sh7FFF;
	localparam sample_t SAT_MIN = 16'sh8000;

	typedef struct packed {
		logic              operation;
		sample_t           sample_in;
		logic              end_of_block;
		logic [CIDX_W-1:0] coef_index;
		sample_t           coef_value;
	} in_item_t;

	typedef struct packed {
		sample_t filtered_sample;
		logic    saturated;
		logic    last_of_block;
	} out_item_t;

	// Common step control broadcast to every tap cell
	typedef struct packed {
		logic step;
		logic clear;
	} step_ctrl_t;

endpackage

// ----- rtl/core/firsat_if.sv -----
// ----------------------------------------------------------------------------
// firsat_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
interface firsat_in_if;
	logic                 valid;
	logic                 ready;
	firsat_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface firsat_out_if;
	logic                  valid;
	logic                  ready;
	firsat_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/firsat_cell.sv -----
// ----------------------------------------------------------------------------
// firsat_cell
// One tap of the delay chain: holds a delay sample and a coefficient, hands
// its sample to the next cell and registers its product on every step.
// ----------------------------------------------------------------------------
module firsat_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  firsat_pkg::step_ctrl_t              ctrl,
	input  logic                                use_tap,
	input  firsat_pkg::sample_t                 x_in,
	input  logic                                coef_we,
	input  firsat_pkg::sample_t                 coef_wdata,
	output firsat_pkg::sample_t                 x_out,
	output logic signed [firsat_pkg::PROD_W-1:0] prod_s1
);

	firsat_pkg::sample_t delay_q;
	firsat_pkg::sample_t coef_q;
	firsat_pkg::sample_t coef_eff;

	// Shift the delay sample, drop the whole chain at the end of a block, load a written coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			coef_q  <= '0;
		end else begin
			if (ctrl.step) begin
				delay_q <= ctrl.clear ? '0 : x_in;
			end
			if (coef_we) begin
				coef_q <= coef_wdata;
			end
		end
	end

	// Taps beyond the count in use contribute nothing
	assign coef_eff = use_tap ? coef_q : '0;

	// Product of the sample entering this tap on this step
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			prod_s1 <= coef_eff * x_in;
		end
	end

	assign x_out = delay_q;

endmodule

// ----- rtl/core/firsat_tree.sv -----
// ----------------------------------------------------------------------------
// firsat_tree
// Registered binary adder tree over the tap products, each level registered.
// ----------------------------------------------------------------------------
module firsat_tree #(
	parameter int N = 32,
	parameter int W = 37
) (
	input  logic                                 clk,
	input  logic [((N > 1) ? $clog2(N) : 1)-1:0] en,
	input  logic signed [firsat_pkg::PROD_W-1:0] leaf [N],
	output logic signed [W-1:0]                  root
);

	localparam int LV = (N > 1) ? $clog2(N) : 0;
	localparam int P  = 1 << LV;

	logic signed [W-1:0] leaf_x [P];

	// Sign-extend the products, pad the tree with zero leaves
	for (genvar j = 0; j < P; j++) begin : g_leaf
		if (j < N) begin : g_used
			assign leaf_x[j] = W'(leaf[j]);
		end else begin : g_pad
			assign leaf_x[j] = '0;
		end
	end

	if (LV == 0) begin : g_flat
		assign root = leaf_x[0];
	end else begin : g_heap
		// Heap order: node 1 is the root, node k adds nodes 2k and 2k+1
		logic signed [W-1:0] node_q [1:P-1];

		for (genvar k = 1; k < P; k++) begin : g_node
			localparam int LVL = LV - ($clog2(k + 1) - 1);
			if (2 * k >= P) begin : g_bot
				always_ff @(posedge clk) begin
					if (en[LVL-1]) begin
						node_q[k] <= leaf_x[2*k-P] + leaf_x[2*k+1-P];
					end
				end
			end else begin : g_mid
				always_ff @(posedge clk) begin
					if (en[LVL-1]) begin
						node_q[k] <= node_q[2*k] + node_q[2*k+1];
					end
				end
			end
		end

		assign root = node_q[1];
	end

endmodule

// ----- rtl/core/fir_filter_int16_saturating.sv -----
// ----------------------------------------------------------------------------
// fir_filter_int16_saturating
// Pipeline: an accepted sample's result passes the product register, the
//   adder tree levels and the rounding and saturation register.
// Throughput: one sample per cycle unless results back up; an end of block adds
//   clamped tap_count-1 flush steps, one per cycle, while input is held off.
//   A coefficient write takes an input transaction but no filter step.
// Reset: delay chain and coefficients clear to zero, tap_count to 21, at once.
// ----------------------------------------------------------------------------
module fir_filter_int16_saturating #(
	parameter int MAX_TAPS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	firsat_in_if.sink           samples,
	firsat_out_if.source        results,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int LV    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0;
	localparam int ENW   = (LV > 0) ? LV : 1;
	localparam int NS    = LV + 2;
	localparam int ACC_W = firsat_pkg::PROD_W + LV;
	localparam int CMPW  = ($clog2(MAX_TAPS + 1) > firsat_pkg::TAPS_W) ?
	                       $clog2(MAX_TAPS + 1) : firsat_pkg::TAPS_W;
	localparam int FB    = firsat_pkg::COEF_FRAC_BITS;
	localparam int YW    = ACC_W - FB;
	localparam int SW    = firsat_pkg::SAMPLE_W;

	logic [firsat_pkg::TAPS_W-1:0] tap_count_q;
	logic [firsat_pkg::TAPS_W-1:0] ntaps;
	logic [firsat_pkg::TAPS_W-1:0] remain_q;
	logic                          flush_q;

	logic                          accept;
	logic                          take_sample;
	logic                          take_coef;
	logic                          flush_step;
	logic                          step_last;
	firsat_pkg::step_ctrl_t        ctrl;
	firsat_pkg::sample_t           x_feed;

	logic [NS-1:0]                 en;
	logic [NS-1:0]                 vld_q;
	logic [NS-1:0]                 last_q;

	firsat_pkg::sample_t                  cell_x   [MAX_TAPS];
	firsat_pkg::sample_t                  tap_in   [MAX_TAPS];
	logic signed [firsat_pkg::PROD_W-1:0] prod     [MAX_TAPS];
	logic [MAX_TAPS-1:0]                  use_tap;
	logic [MAX_TAPS-1:0]                  coef_we;
	logic [ENW-1:0]                       tree_en;

	logic signed [ACC_W-1:0]       root;
	logic [ACC_W-1:0]              rnd_sum;
	logic [YW-1:0]                 rnd_y;
	logic [YW-SW:0]                rnd_hi;
	logic                          rnd_sat;
	firsat_pkg::sample_t           rnd_val;
	firsat_pkg::sample_t           out_val_q;
	logic                          out_sat_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= firsat_pkg::TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == firsat_pkg::REG_TAP_COUNT) begin
			tap_count_q <= pwdata[firsat_pkg::TAPS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			firsat_pkg::REG_TAP_COUNT: prdata = 32'(tap_count_q);
			default: prdata = '0;
		endcase
	end

	// Clamp the tap count to one at least and to the chain length at most
	always_comb begin
		if (tap_count_q == '0) begin
			ntaps = firsat_pkg::TAPS_W'(1);
		end else if (CMPW'(tap_count_q) > CMPW'(MAX_TAPS)) begin
			ntaps = firsat_pkg::TAPS_W'(MAX_TAPS);
		end else begin
			ntaps = tap_count_q;
		end
	end

	// ---------------- pipeline advance ----------------
	// A stage loads when it is empty or its successor moves on
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || results.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// ---------------- input and flush control ----------------
	assign samples.ready = !flush_q && en[0];
	assign accept        = samples.valid && samples.ready;
	assign take_sample   = accept && samples.data.operation == firsat_pkg::OP_SAMPLE;
	assign take_coef     = accept && samples.data.operation == firsat_pkg::OP_COEF;
	assign flush_step    = flush_q && en[0];

	assign x_feed    = flush_q ? '0 : samples.data.sample_in;
	assign step_last = flush_q ? (remain_q == firsat_pkg::TAPS_W'(1)) :
	                   (samples.data.end_of_block && ntaps == firsat_pkg::TAPS_W'(1));

	assign ctrl.step  = take_sample || flush_step;
	assign ctrl.clear = step_last;

	// Count the tail steps that feed zeros after an end of block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q  <= 1'b0;
			remain_q <= '0;
		end else if (take_sample && samples.data.end_of_block &&
		             ntaps != firsat_pkg::TAPS_W'(1)) begin
			flush_q  <= 1'b1;
			remain_q <= ntaps - firsat_pkg::TAPS_W'(1);
		end else if (flush_step) begin
			remain_q <= remain_q - firsat_pkg::TAPS_W'(1);
			if (remain_q == firsat_pkg::TAPS_W'(1)) begin
				flush_q <= 1'b0;
			end
		end
	end

	// ---------------- tap chain ----------------
	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign tap_in[i] = x_feed;
		end else begin : g_link
			assign tap_in[i] = cell_x[i-1];
		end
		assign use_tap[i] = CMPW'(i) < CMPW'(ntaps);
		assign coef_we[i] = take_coef && (CMPW'(samples.data.coef_index) == CMPW'(i));

		firsat_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.use_tap    (use_tap[i]),
			.x_in       (tap_in[i]),
			.coef_we    (coef_we[i]),
			.coef_wdata (samples.data.coef_value),
			.x_out      (cell_x[i]),
			.prod_s1    (prod[i])
		);
	end

	// ---------------- adder tree ----------------
	if (LV > 0) begin : g_tree_en
		assign tree_en = en[LV:1];
	end else begin : g_tree_en0
		assign tree_en = 1'b0;
	end

	firsat_tree #(
		.N (MAX_TAPS),
		.W (ACC_W)
	) u_tree (
		.clk  (clk),
		.en   (tree_en),
		.leaf (prod),
		.root (root)
	);

	// ---------------- stage valid and end-of-block marks ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= ctrl.step;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			last_q[0] <= step_last;
		end
		for (int k = 1; k < NS; k++) begin
			if (en[k]) begin
				last_q[k] <= last_q[k-1];
			end
		end
	end

	// ---------------- round half away from zero, saturate ----------------
	// Negative sums take half minus one so that a floor gives away-from-zero
	assign rnd_sum = root + ACC_W'(1 << (FB - 1)) - ACC_W'(root[ACC_W-1]);
	assign rnd_y   = rnd_sum[ACC_W-1:FB];
	assign rnd_hi  = rnd_y[YW-1:SW-1];
	assign rnd_sat = !((&rnd_hi) || !(|rnd_hi));
	assign rnd_val = rnd_sat ? (rnd_y[YW-1] ? firsat_pkg::SAT_MIN : firsat_pkg::SAT_MAX) :
	                 rnd_y[SW-1:0];

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			out_val_q <= rnd_val;
			out_sat_q <= rnd_sat;
		end
	end

	assign results.valid                = vld_q[NS-1];
	assign results.data.filtered_sample = out_val_q;
	assign results.data.saturated       = out_sat_q;
	assign results.data.last_of_block   = last_q[NS-1];

`ifndef SYNTH
	// An end of block on more than one tap starts the tail
	a_flush_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take_sample && samples.data.end_of_block && ntaps != firsat_pkg::TAPS_W'(1))
		|=> flush_q)
		else $error("tail flush did not start after end of block");

	// The tail always has steps left while it runs
	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> remain_q != '0)
		else $error("tail flush running with no steps left");

	// The last step of a block leaves the delay chain at zero
	a_chain_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && ctrl.clear) |=> (cell_x[0] == '0 && cell_x[MAX_TAPS-1] == '0))
		else $error("delay chain not cleared at end of block");

	// A result leaves only from a filled stage ahead of it
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(vld_q[NS-1])) |-> $past(vld_q[NS-2]))
		else $error("result appeared without a stage feeding it");
`endif

endmodule
